[rtl/kwm_pkg.sv]
// Package: shared types, constants and state codes for the k-way merge unit.
`timescale 1ns / 1ps
package kwm_pkg;
	localparam int SOURCES_DEF       = 16;
	localparam int KEY_WORDS_MAX_DEF = 5;
	localparam int KEY_W             = 32 * KEY_WORDS_MAX_DEF;
	localparam int CFG_IDX_W         = 1;
	localparam int CFG_DATA_W        = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORDS    = 1'd1;

	typedef struct packed {
		logic [3:0]         in_source;
		logic               in_end;
		logic [31:0]        in_key0;
		logic [31:0]        in_key1;
		logic [31:0]        in_key2;
		logic [31:0]        in_key3;
		logic [31:0]        in_key4;
		logic signed [63:0] in_count;
	} in_item_t;

	typedef struct packed {
		logic               out_valid;
		logic [31:0]        out_key0;
		logic [31:0]        out_key1;
		logic [31:0]        out_key2;
		logic [31:0]        out_key3;
		logic [31:0]        out_key4;
		logic signed [63:0] out_count;
		logic [3:0]         next_source;
		logic               all_done;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIFT_UP,
		ST_POP_START,
		ST_SIFT_DOWN,
		ST_EMIT
	} eng_state_t;

	// Masks key words at or beyond the active word count.
	function automatic logic [KEY_W-1:0] key_mask(input logic [2:0] kw);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int j = 0; j < KEY_WORDS_MAX_DEF; j++)
			if (j < int'(kw)) m[KEY_W-1-32*j -: 32] = '1;
		return m;
	endfunction
endpackage

[rtl/kwm_front.sv]
// Front part: two-entry input queue; flags whether its head item is for the awaited source before the end.
`timescale 1ns / 1ps
module kwm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  kwm_pkg::in_item_t  in_item,
	input  logic [3:0]         pend_src,
	input  logic               done,
	output logic               q_valid,
	output kwm_pkg::in_item_t  q_item,
	output logic               q_take_ok,
	input  logic               q_take
);
	// two-entry queue
	kwm_pkg::in_item_t buf_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr;

	assign full      = (cnt_q == 2'd2);
	assign wr        = push && !full;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = buf_q[rd_q];
	// item is for the awaited source and the merge is not done; otherwise it only gets a status result
	assign q_take_ok = !done && (q_item.in_source == pend_src);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, q_take};
			if (q_take) rd_q <= !rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) buf_q[rd_q ^ cnt_q[0]] <= in_item;
	end
endmodule

[rtl/kwm_back.sv]
// Back part: head store, min-heap sequencer and merge accumulator.
`timescale 1ns / 1ps
module kwm_back #(
	parameter int SOURCES       = kwm_pkg::SOURCES_DEF,
	parameter int KEY_WORDS_MAX = kwm_pkg::KEY_WORDS_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         cfg_sources,
	input  logic [2:0]         cfg_words,
	input  logic               q_valid,
	input  kwm_pkg::in_item_t  q_item,
	input  logic               q_take_ok,
	output logic               q_take,
	output logic [3:0]         pend_src,
	output logic               done,
	input  logic               res_full,
	output logic               res_push,
	output kwm_pkg::out_item_t res_item
);
	localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int CW = $clog2(SOURCES + 1);
	localparam int KW = kwm_pkg::KEY_W;

	logic [KW-1:0]      hkey_q  [SOURCES];
	logic signed [63:0] hcnt_q  [SOURCES];
	logic [SW-1:0]      slot_q  [SOURCES];
	logic [CW-1:0]      size_q, load_q, idx_q;
	logic [SW-1:0]      pend_q, top_q;
	logic [KW-1:0]      mkey_q;
	logic signed [63:0] mcnt_q;
	logic               mval_q, fin_q;
	logic               emit_q;
	logic [KW-1:0]      ekey_q;
	logic signed [63:0] ecnt_q;
	kwm_pkg::eng_state_t st_q, st_d;

	logic [2:0]    kw_eff;
	logic [CW-1:0] cnt_eff;
	logic [KW-1:0] mask;

	always_comb begin
		kw_eff = cfg_words;
		if (cfg_words == 3'd0) kw_eff = 3'd1;
		else if (int'(cfg_words) > KEY_WORDS_MAX) kw_eff = 3'(KEY_WORDS_MAX);
		cnt_eff = CW'(cfg_sources);
		if (cfg_sources == 5'd0) cnt_eff = CW'(1);
		else if (int'(cfg_sources) > SOURCES) cnt_eff = CW'(SOURCES);
	end
	assign mask = kwm_pkg::key_mask(kw_eff);

	function automatic logic less(input logic [SW-1:0] a, input logic [SW-1:0] b,
			input logic [KW-1:0] ka, input logic [KW-1:0] kb, input logic [KW-1:0] m);
		logic [KW-1:0] x, y;
		x = ka & m;
		y = kb & m;
		if (x != y) return x < y;
		return a < b;
	endfunction

	// sift cursors and comparison operands
	logic [CW-1:0] par, lch, rch, mi;
	logic [SW-1:0] si, sp, sl, sr, sm;
	logic          up_swap;
	always_comb begin
		par = (idx_q - CW'(1)) >> 1;
		lch = CW'({idx_q, 1'b1});
		rch = lch + CW'(1);
		si  = slot_q[idx_q[SW-1:0]];
		sp  = slot_q[par[SW-1:0]];
		sl  = (lch < size_q) ? slot_q[lch[SW-1:0]] : si;
		sr  = (rch < size_q) ? slot_q[rch[SW-1:0]] : si;
		up_swap = (idx_q != '0) && less(si, sp, hkey_q[si], hkey_q[sp], mask);
		mi = idx_q;
		sm = si;
		if (lch < size_q && less(sl, sm, hkey_q[sl], hkey_q[sm], mask)) begin
			mi = lch;
			sm = sl;
		end
		if (rch < size_q && less(sr, sm, hkey_q[sr], hkey_q[sm], mask)) begin
			mi = rch;
			sm = sr;
		end
	end

	logic          acc, is_rec, in_load, go_pop;
	logic [CW-1:0] load_nx;
	logic [SW-1:0] src;
	assign src     = q_item.in_source[SW-1:0];
	assign acc     = (st_q == kwm_pkg::ST_IDLE) && q_valid && q_take_ok
		&& (int'(q_item.in_source) < SOURCES);
	assign is_rec  = !q_item.in_end && (int'(size_q) < SOURCES);
	assign in_load = load_q < cnt_eff;
	assign load_nx = load_q + CW'(1);
	assign go_pop  = !in_load || (load_nx >= cnt_eff);
	assign q_take  = (st_q == kwm_pkg::ST_IDLE) && q_valid;

	logic go_flag_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			kwm_pkg::ST_IDLE:
				if (acc) begin
					if (is_rec) st_d = kwm_pkg::ST_SIFT_UP;
					else if (go_pop) st_d = kwm_pkg::ST_POP_START;
					else st_d = kwm_pkg::ST_EMIT;
				end else if (q_valid) begin
					// ignored item still gets a status result
					st_d = kwm_pkg::ST_EMIT;
				end
			kwm_pkg::ST_SIFT_UP:
				if (!up_swap) st_d = go_flag_q ? kwm_pkg::ST_POP_START : kwm_pkg::ST_EMIT;
			kwm_pkg::ST_POP_START:
				st_d = (size_q == '0) ? kwm_pkg::ST_EMIT : kwm_pkg::ST_SIFT_DOWN;
			kwm_pkg::ST_SIFT_DOWN:
				if (mi == idx_q) st_d = kwm_pkg::ST_EMIT;
			kwm_pkg::ST_EMIT:
				if (!res_full) st_d = kwm_pkg::ST_IDLE;
			default: st_d = kwm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= kwm_pkg::ST_IDLE;
			size_q    <= '0;
			load_q    <= '0;
			pend_q    <= '0;
			mval_q    <= 1'b0;
			fin_q     <= 1'b0;
			emit_q    <= 1'b0;
			go_flag_q <= 1'b0;
			idx_q     <= '0;
			top_q     <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				kwm_pkg::ST_IDLE:
					if (acc) begin
						emit_q    <= 1'b0;
						go_flag_q <= go_pop;
						if (is_rec) begin
							idx_q  <= size_q;
							size_q <= size_q + CW'(1);
						end
						if (in_load) begin
							load_q <= load_nx;
							if (load_nx < cnt_eff) pend_q <= load_nx[SW-1:0];
						end
					end else if (q_valid) begin
						emit_q <= 1'b0;
					end
				kwm_pkg::ST_SIFT_UP:
					if (up_swap) idx_q <= par;
				kwm_pkg::ST_POP_START: begin
					idx_q <= '0;
					if (size_q == '0) begin
						emit_q <= mval_q;
						mval_q <= 1'b0;
						fin_q  <= 1'b1;
					end else begin
						size_q <= size_q - CW'(1);
						top_q  <= slot_q[0];
					end
				end
				kwm_pkg::ST_SIFT_DOWN:
					if (mi != idx_q) idx_q <= mi;
					else begin
						pend_q <= top_q;
						if (mval_q && ((mkey_q & mask) == (hkey_q[top_q] & mask))) begin
							mcnt_q <= mcnt_q + hcnt_q[top_q];
						end else begin
							emit_q <= mval_q;
							mval_q <= 1'b1;
							mkey_q <= hkey_q[top_q] & mask;
							mcnt_q <= hcnt_q[top_q];
						end
					end
				default: ;
			endcase
		end
	end

	// payload stores
	always_ff @(posedge clk) begin
		if (acc && is_rec) begin
			hkey_q[src] <= {q_item.in_key0, q_item.in_key1, q_item.in_key2,
				q_item.in_key3, q_item.in_key4} & mask;
			hcnt_q[src] <= q_item.in_count;
			slot_q[size_q[SW-1:0]] <= src;
		end
		if (st_q == kwm_pkg::ST_SIFT_UP && up_swap) begin
			slot_q[par[SW-1:0]]   <= si;
			slot_q[idx_q[SW-1:0]] <= sp;
		end
		if (st_q == kwm_pkg::ST_POP_START && size_q != '0)
			slot_q[0] <= slot_q[size_q[SW-1:0] - SW'(1)];
		if (st_q == kwm_pkg::ST_SIFT_DOWN && mi != idx_q) begin
			slot_q[idx_q[SW-1:0]] <= sm;
			slot_q[mi[SW-1:0]]    <= si;
		end
		if (st_q == kwm_pkg::ST_POP_START || st_q == kwm_pkg::ST_SIFT_DOWN) begin
			ekey_q <= mkey_q & mask;
			ecnt_q <= mcnt_q;
		end
	end

	assign pend_src = 4'(pend_q);
	assign done     = fin_q;
	assign res_push = (st_q == kwm_pkg::ST_EMIT) && !res_full;

	always_comb begin
		res_item             = '0;
		res_item.out_valid   = emit_q;
		if (emit_q) begin
			res_item.out_key0  = ekey_q[KW-1   -: 32];
			res_item.out_key1  = ekey_q[KW-33  -: 32];
			res_item.out_key2  = ekey_q[KW-65  -: 32];
			res_item.out_key3  = ekey_q[KW-97  -: 32];
			res_item.out_key4  = ekey_q[KW-129 -: 32];
			res_item.out_count = ecnt_q;
		end
		res_item.next_source = 4'(pend_q);
		res_item.all_done    = fin_q;
	end

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		int'(size_q) <= SOURCES) else $error("heap size over capacity");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fin_q) |-> fin_q) else $error("all_done fell");
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> st_q == kwm_pkg::ST_EMIT) else $error("result outside emit");
endmodule

[rtl/k_way_merge_aggregate_unit.sv]
// Top level: k-way merge with count aggregation.
// channel | dir | handshake          | payload
// input   | in  | push / full        | in_item  (in_item_t)
// result  | out | pop / empty        | out_item (out_item_t)
// config  | in  | cfg_we             | cfg_index, cfg_data
// Each accepted item gives one result. An item leaves the input queue and passes through
// accept, sift-up for a record, pop and sift-down once loading is done, and result;
// one heap level a cycle. An ignored item goes from accept straight to result.
// Reset clears control; head and merge stores are written before use.
// A full result queue holds the engine in its result state; a push into a full input queue is dropped.
`timescale 1ns / 1ps
module k_way_merge_aggregate_unit #(
	parameter int SOURCES       = kwm_pkg::SOURCES_DEF,
	parameter int KEY_WORDS_MAX = kwm_pkg::KEY_WORDS_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  kwm_pkg::in_item_t               in_item,
	output logic                            empty,
	input  logic                            pop,
	output kwm_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [kwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	logic [4:0] src_cnt_q;
	logic [2:0] words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= 5'd16;
			words_q   <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kwm_pkg::CFG_SOURCE_COUNT: src_cnt_q <= cfg_data;
				kwm_pkg::CFG_KEY_WORDS:    words_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic              q_valid, q_take_ok, q_take, done, res_push;
	logic [3:0]        pend_src;
	kwm_pkg::in_item_t q_item;
	kwm_pkg::out_item_t res_item;

	kwm_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.pend_src, .done, .q_valid, .q_item, .q_take_ok, .q_take
	);

	// result queue
	kwm_pkg::out_item_t rbuf_q [2];
	logic [1:0] rcnt_q;
	logic       rrd_q, rpop, rfull;
	assign rfull = (rcnt_q == 2'd2);
	assign empty = (rcnt_q == 2'd0);
	assign rpop  = pop && !empty;
	assign out_item = rbuf_q[rrd_q];

	kwm_back #(.SOURCES(SOURCES), .KEY_WORDS_MAX(KEY_WORDS_MAX)) u_back (
		.clk, .arst_n, .cfg_sources(src_cnt_q), .cfg_words(words_q),
		.q_valid, .q_item, .q_take_ok, .q_take, .pend_src, .done,
		.res_full(rfull), .res_push, .res_item
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			rrd_q  <= 1'b0;
		end else begin
			rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, rpop};
			if (rpop) rrd_q <= !rrd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) rbuf_q[rrd_q ^ rcnt_q[0]] <= res_item;
	end

	a_rq: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !rfull) else $error("result queue overflow");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q == 2'd1 && rpop && !res_push) |=> empty) else $error("queue count");
	a_noinv: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !$past(res_push)) |-> rcnt_q == 2'd0) else $error("invented result");
endmodule
